// ----- hdl/bmp_rle8_pkg.sv -----
// ----------------------------------------------------------------------------
// BMP RLE8 decoder package
// Shared codes, screen size and the RGB565 color packing.
// ----------------------------------------------------------------------------
package bmp_rle8_pkg;

  // screen the spans are clipped to
  localparam int unsigned DISPLAY_WIDTH  = 480;
  localparam int unsigned DISPLAY_HEIGHT = 320;

  localparam int unsigned COL_W = 12;  // cursor column, 0..4095
  localparam int unsigned ROW_W = 13;  // cursor row, signed, -1..4095

  // input word kinds
  localparam logic [1:0] ACT_PALETTE = 2'd0;
  localparam logic [1:0] ACT_BYTE    = 2'd1;
  localparam logic [1:0] ACT_BEGIN   = 2'd2;

  // second byte of an escape pair
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  localparam logic [COL_W-1:0] COL_MAX = '1;
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(4095);
  localparam logic [ROW_W-1:0] ROW_MIN = '1;  // -1

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_FIRST  = 8'b0000_0010,
    PH_SECOND = 8'b0000_0100,
    PH_DX     = 8'b0000_1000,
    PH_DY     = 8'b0001_0000,
    PH_ABS    = 8'b0010_0000,
    PH_PAD    = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_t;

  function automatic logic [15:0] to_rgb565(input logic [23:0] c);
    logic [15:0] p;
    p = {c[23:19], c[15:10], c[7:3]};
    return p;
  endfunction

endpackage

// ----- hdl/bmp_rle8_span_decoder.sv -----
// ----------------------------------------------------------------------------
// BMP RLE8 span decoder
// Parses an RLE8 byte stream into clipped RGB565 spans for the display.
// ----------------------------------------------------------------------------
//  channel  | signals                                            | dir
//  ---------+----------------------------------------------------+-----
//  input    | in_valid in_ready action palette_index             | in
//           | palette_color stream_byte                          |
//  output   | out_valid out_ready span_x span_y span_length      | out
//           | pixel_color image_done                             |
//  config   | cfg_write cfg_data (image_height)                  | in
//
//  One word is taken per cycle. The parser state updates at acceptance; a
//  span word passes through the palette read stage and then sits in the
//  output register. Input is held off only while both the read stage and
//  the output register are full and out_ready is low. Reset (rst,
//  synchronous) clears the parser, the palette valid bits (all entries
//  read as zero) and image_height to 320.
// ----------------------------------------------------------------------------
module bmp_rle8_span_decoder #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_write,
  input  logic [12:0] cfg_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  palette_index,
  input  logic [23:0] palette_color,
  input  logic [7:0]  stream_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  span_x,
  output logic [8:0]  span_y,
  output logic [7:0]  span_length,
  output logic [15:0] pixel_color,
  output logic        image_done
);

  import bmp_rle8_pkg::*;

  localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] DEPTH_L = 9'(PALETTE_DEPTH);
  localparam logic [COL_W-1:0] WIDTH_L  = COL_W'(DISPLAY_WIDTH);
  localparam logic [COL_W-1:0] HEIGHT_L = COL_W'(DISPLAY_HEIGHT);

  // configuration
  logic [12:0] image_height;

  // parser state
  phase_t           phase, phase_next;
  logic [7:0]       first_byte, first_byte_next;
  logic [COL_W-1:0] column, column_next;
  logic [ROW_W-1:0] row, row_next;
  logic [7:0]       remaining, remaining_next;
  logic             pad_needed, pad_needed_next;

  // palette
  logic [15:0]              palette [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] pal_valid;
  logic [15:0]              pal_data;
  logic                     pal_hit;

  // read stage
  logic       a_valid;
  logic       a_done;
  logic [8:0] a_x;
  logic [8:0] a_y;
  logic [7:0] a_len;

  logic in_fire, a_move;
  logic is_write, idx_ok;

  // span arithmetic
  logic [7:0]       span_count;
  logic             span_vis;
  logic [COL_W-1:0] room;
  logic [7:0]       span_len;
  logic [COL_W:0]   col_sum;
  logic [COL_W-1:0] col_adv;
  logic [COL_W-1:0] col_delta;
  logic [7:0]       drop_n;
  logic signed [ROW_W:0] row_diff;
  logic [ROW_W-1:0] row_drop;
  logic [ROW_W-1:0] start_row;

  logic produce, produce_done;

  assign a_move   = a_valid && (!out_valid || out_ready);
  assign in_ready = !a_valid || !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign idx_ok   = {1'b0, palette_index} < DEPTH_L;
  assign is_write = in_fire && (action == ACT_PALETTE) && idx_ok;

  // span at the cursor: pair count in the second phase, one pixel otherwise
  assign span_count = (phase == PH_SECOND) ? first_byte : 8'd1;
  assign span_vis   = !row[ROW_W-1] && (row[COL_W-1:0] < HEIGHT_L) &&
                      (column < WIDTH_L) && (span_count != 8'd0);
  assign room       = WIDTH_L - column;
  assign span_len   = ({4'd0, span_count} < room) ? span_count : room[7:0];
  assign col_sum    = {1'b0, column} + {5'd0, span_count};
  assign col_adv    = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];

  // delta column move
  always_comb begin
    logic [COL_W:0] s;
    s = {1'b0, column} + {5'd0, stream_byte};
    col_delta = s[COL_W] ? COL_MAX : s[COL_W-1:0];
  end

  // row drop, saturating at -1
  assign drop_n   = (phase == PH_DY) ? stream_byte : 8'd1;
  assign row_diff = $signed({row[ROW_W-1], row}) - $signed({6'd0, drop_n});
  assign row_drop = (row_diff < -14'sd1) ? ROW_MIN : row_diff[ROW_W-1:0];

  // first row of a new image
  always_comb begin
    if (image_height == 13'd0) begin
      start_row = ROW_MIN;
    end else if (image_height > 13'd4096) begin
      start_row = ROW_MAX;
    end else begin
      start_row = image_height - 13'd1;
    end
  end

  always_comb begin
    phase_next      = phase;
    first_byte_next = first_byte;
    column_next     = column;
    row_next        = row;
    remaining_next  = remaining;
    pad_needed_next = pad_needed;
    produce         = 1'b0;
    produce_done    = 1'b0;
    if (in_fire) begin
      case (action)
        ACT_BEGIN: begin
          row_next        = start_row;
          column_next     = '0;
          first_byte_next = '0;
          remaining_next  = '0;
          pad_needed_next = 1'b0;
          phase_next      = PH_FIRST;
        end
        ACT_BYTE: begin
          case (phase)
            PH_FIRST: begin
              first_byte_next = stream_byte;
              phase_next      = PH_SECOND;
            end
            PH_SECOND: begin
              if (first_byte != 8'd0) begin
                produce     = span_vis;
                column_next = col_adv;
                phase_next  = PH_FIRST;
              end else if (stream_byte == ESC_EOL) begin
                column_next = '0;
                row_next    = row_drop;
                phase_next  = PH_FIRST;
              end else if (stream_byte == ESC_EOB) begin
                produce      = 1'b1;
                produce_done = 1'b1;
                phase_next   = PH_DONE;
              end else if (stream_byte == ESC_DELTA) begin
                phase_next = PH_DX;
              end else begin
                remaining_next  = stream_byte;
                pad_needed_next = stream_byte[0];
                phase_next      = PH_ABS;
              end
            end
            PH_DX: begin
              column_next = col_delta;
              phase_next  = PH_DY;
            end
            PH_DY: begin
              row_next   = row_drop;
              phase_next = PH_FIRST;
            end
            PH_ABS: begin
              produce        = span_vis;
              column_next    = col_adv;
              remaining_next = remaining - 8'd1;
              if (remaining == 8'd1) begin
                phase_next = pad_needed ? PH_PAD : PH_FIRST;
              end
            end
            PH_PAD: begin
              pad_needed_next = 1'b0;
              phase_next      = PH_FIRST;
            end
            default: begin
              // idle or done: drop the byte
            end
          endcase
        end
        default: begin
          // palette writes go straight to the table; unknown kinds drop
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_height <= 13'd320;
      phase        <= PH_IDLE;
      first_byte   <= '0;
      column       <= '0;
      row          <= '0;
      remaining    <= '0;
      pad_needed   <= 1'b0;
    end else begin
      if (cfg_write) begin
        image_height <= cfg_data;
      end
      phase      <= phase_next;
      first_byte <= first_byte_next;
      column     <= column_next;
      row        <= row_next;
      remaining  <= remaining_next;
      pad_needed <= pad_needed_next;
    end
  end

  // palette store, read at acceptance with the stream byte as address
  always_ff @(posedge clk) begin
    if (is_write) begin
      palette[palette_index[IDX_W-1:0]] <= to_rgb565(palette_color);
    end
    if (in_fire) begin
      pal_data <= palette[stream_byte[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= '0;
      pal_hit   <= 1'b0;
    end else begin
      if (is_write) begin
        pal_valid[palette_index[IDX_W-1:0]] <= 1'b1;
      end
      if (in_fire) begin
        pal_hit <= pal_valid[stream_byte[IDX_W-1:0]] &&
                   ({1'b0, stream_byte} < DEPTH_L);
      end
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= produce;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_done <= produce_done;
      a_x    <= produce_done ? 9'd0 : column[8:0];
      a_y    <= produce_done ? 9'd0 : row[8:0];
      a_len  <= produce_done ? 8'd0 : span_len;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      span_x      <= a_x;
      span_y      <= a_y;
      span_length <= a_len;
      image_done  <= a_done;
      pixel_color <= (!a_done && pal_hit) ? pal_data : 16'd0;
    end
  end

endmodule

// ----- tb/rle8_span_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RLE8 span checker
// Watches the word and span channels of the decoder, keeps its own copy of
// the palette, cursor and parser, and compares every span word it sees with
// the oldest span it has predicted.
// ----------------------------------------------------------------------------
module rle8_span_checker (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_write,
  input  logic [12:0] cfg_data,

  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  palette_index,
  input  logic [23:0] palette_color,
  input  logic [7:0]  stream_byte,

  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [8:0]  span_x,
  input  logic [8:0]  span_y,
  input  logic [7:0]  span_length,
  input  logic [15:0] pixel_color,
  input  logic        image_done,

  output int          mismatches,
  output int          pending_spans,
  output int          spans_checked,
  output int          images_closed
);

  import bmp_rle8_pkg::*;

  typedef struct packed {
    logic [8:0]  x;
    logic [8:0]  y;
    logic [7:0]  len;
    logic [15:0] color;
    logic        done;
  } span_word_t;

  span_word_t        predicted_spans[$];

  logic [15:0]       palette_rgb [256];
  logic [12:0]       height_reg;
  phase_t            phase;
  logic [7:0]        pair_count;
  logic [11:0]       col;
  logic signed [12:0] row;
  logic [7:0]        abs_left;
  logic              abs_pad;

  task automatic advance_col(input int n);
    int c;
    c = int'(col) + n;
    col = (c > int'(COL_MAX)) ? COL_MAX : 12'(c);
  endtask

  task automatic drop_rows(input int n);
    int r;
    r = int'(row) - n;
    row = (r < -1) ? ROW_MIN : 13'(r);
  endtask

  // Clip a run of pixels at the cursor to the screen, queue it if visible and advance the column.
  task automatic emit_span(input int count, input logic [15:0] color);
    int c;
    int r;
    int len;
    span_word_t w;
    c = int'(col);
    r = int'(row);
    if (r >= 0 && r < int'(DISPLAY_HEIGHT) && c < int'(DISPLAY_WIDTH) && count > 0) begin
      len = count;
      if (len > int'(DISPLAY_WIDTH) - c) len = int'(DISPLAY_WIDTH) - c;
      w.x = 9'(c);
      w.y = 9'(r);
      w.len = 8'(len);
      w.color = color;
      w.done = 1'b0;
      predicted_spans.push_back(w);
    end
    advance_col(count);
  endtask

  task automatic take_byte(input logic [7:0] b);
    span_word_t w;
    case (phase)
      PH_FIRST: begin
        pair_count = b;
        phase = PH_SECOND;
      end
      PH_SECOND: begin
        if (pair_count != 8'd0) begin
          phase = PH_FIRST;
          emit_span(int'(pair_count), palette_rgb[b]);
        end else if (b == ESC_EOL) begin
          col = '0;
          drop_rows(1);
          phase = PH_FIRST;
        end else if (b == ESC_EOB) begin
          phase = PH_DONE;
          w = '0;
          w.done = 1'b1;
          predicted_spans.push_back(w);
        end else if (b == ESC_DELTA) begin
          phase = PH_DX;
        end else begin
          abs_left = b;
          abs_pad = b[0];
          phase = PH_ABS;
        end
      end
      PH_DX: begin
        advance_col(int'(b));
        phase = PH_DY;
      end
      PH_DY: begin
        drop_rows(int'(b));
        phase = PH_FIRST;
      end
      PH_ABS: begin
        emit_span(1, palette_rgb[b]);
        abs_left = abs_left - 8'd1;
        if (abs_left == 8'd0) phase = abs_pad ? PH_PAD : PH_FIRST;
      end
      PH_PAD: begin
        abs_pad = 1'b0;
        phase = PH_FIRST;
      end
      default: ;
    endcase
  endtask

  task automatic apply_word();
    int start_row;
    case (action)
      ACT_PALETTE: begin
        palette_rgb[palette_index] = {palette_color[23:19], palette_color[15:10],
                                      palette_color[7:3]};
      end
      ACT_BYTE: take_byte(stream_byte);
      ACT_BEGIN: begin
        start_row = int'(height_reg) - 1;
        row = (start_row > 4095) ? ROW_MAX : 13'(start_row);
        col = '0;
        pair_count = '0;
        abs_left = '0;
        abs_pad = 1'b0;
        phase = PH_FIRST;
      end
      default: ;
    endcase
  endtask

  task automatic check_span();
    span_word_t w;
    if (predicted_spans.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: unexpected span word x=%0d y=%0d len=%0d color=%h done=%b",
                 $realtime, span_x, span_y, span_length, pixel_color, image_done);
      mismatches++;
    end else begin
      w = predicted_spans.pop_front();
      spans_checked++;
      if (w.done) images_closed++;
      if (span_x !== w.x || span_y !== w.y || span_length !== w.len ||
          pixel_color !== w.color || image_done !== w.done) begin
        if (mismatches < 10) begin
          $display("%0t: span mismatch", $realtime);
          $display("  expected x=%0d y=%0d len=%0d color=%h done=%b",
                   w.x, w.y, w.len, w.color, w.done);
          $display("  actual   x=%0d y=%0d len=%0d color=%h done=%b",
                   span_x, span_y, span_length, pixel_color, image_done);
        end
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      predicted_spans.delete();
      foreach (palette_rgb[i]) palette_rgb[i] = '0;
      height_reg = 13'd320;
      phase = PH_IDLE;
      pair_count = '0;
      col = '0;
      row = '0;
      abs_left = '0;
      abs_pad = 1'b0;
      mismatches = 0;
      spans_checked = 0;
      images_closed = 0;
    end else begin
      if (out_valid && out_ready) check_span();
      if (cfg_write) height_reg = cfg_data;
      if (in_valid && in_ready) apply_word();
    end
    pending_spans = predicted_spans.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RLE8 span decoder testbench
// Drives palette writes, begin words and RLE8 byte streams (directed corner
// cases, then random images with noise) under several image heights, with
// random stalls on both channels; a checker module predicts the spans.
// ----------------------------------------------------------------------------
module testbench;

  import bmp_rle8_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // total budget, split evenly over the eight heights; whole images overshoot each share
  localparam int RANDOM_WORDS = 480;
  localparam int SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [7:0]  palette_index;
  logic [23:0] palette_color;
  logic [7:0]  stream_byte;
  logic        out_valid;
  logic        out_ready;
  logic [8:0]  span_x;
  logic [8:0]  span_y;
  logic [7:0]  span_length;
  logic [15:0] pixel_color;
  logic        image_done;

  int mismatches;
  int pending_spans;
  int spans_checked;
  int images_closed;

  int  words_sent;
  int  heights_used;
  bit  steady;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bmp_rle8_span_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .palette_index(palette_index),
    .palette_color(palette_color),
    .stream_byte  (stream_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .span_x       (span_x),
    .span_y       (span_y),
    .span_length  (span_length),
    .pixel_color  (pixel_color),
    .image_done   (image_done)
  );

  rle8_span_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .palette_index(palette_index),
    .palette_color(palette_color),
    .stream_byte  (stream_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .span_x       (span_x),
    .span_y       (span_y),
    .span_length  (span_length),
    .pixel_color  (pixel_color),
    .image_done   (image_done),
    .mismatches   (mismatches),
    .pending_spans(pending_spans),
    .spans_checked(spans_checked),
    .images_closed(images_closed)
  );

  // Mostly short gaps, a few long ones, none at all during a steady stretch.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [1:0] act, input logic [7:0] idx,
                           input logic [23:0] rgb, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action = act;
    palette_index = idx;
    palette_color = rgb;
    stream_byte = b;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_word(ACT_BYTE, 8'($urandom), 24'($urandom), b);
  endtask

  task automatic put_palette(input logic [7:0] idx, input logic [23:0] rgb);
    send_word(ACT_PALETTE, idx, rgb, 8'($urandom));
  endtask

  task automatic put_begin();
    send_word(ACT_BEGIN, 8'($urandom), 24'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_spans != 0) @(negedge clk);
    // a word with no span may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_height(input logic [12:0] h);
    wait_drained();
    cfg_data = h;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
    heights_used++;
  endtask

  task automatic put_absolute(input int n);
    put_byte(8'd0);
    put_byte(8'(n));
    repeat (n) put_byte(8'($urandom));
    if (n % 2 == 1) put_byte(8'($urandom));
  endtask

  // One image: begin, optional descent from a tall start row, random opcodes,
  // optional end-of-bitmap followed by a few ignored bytes.
  task automatic make_image(input int ops, input int descend, input bit finish);
    int r;
    int n;
    steady = ($urandom_range(0, 4) == 0);
    put_begin();
    repeat (descend) begin
      put_byte(8'd0);
      put_byte(ESC_DELTA);
      put_byte(8'd0);
      put_byte(8'd255);
    end
    repeat (ops) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 40) : $urandom_range(41, 255);
        put_byte(8'(n));
        put_byte(8'($urandom));
      end else if (r < 55) begin
        put_byte(8'd0);
        put_byte(ESC_EOL);
      end else if (r < 65) begin
        put_byte(8'd0);
        put_byte(ESC_DELTA);
        put_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 30)));
        put_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)));
      end else if (r < 85) begin
        put_absolute(($urandom_range(0, 99) < 95) ? $urandom_range(3, 10)
                                                  : $urandom_range(11, 255));
      end else if (r < 88) begin
        // push the column past its ceiling
        repeat (17) begin
          put_byte(8'd255);
          put_byte(8'($urandom));
        end
      end else if (r < 94) begin
        put_palette(8'($urandom), 24'($urandom));
      end else begin
        send_word(2'($urandom), 8'($urandom), 24'($urandom), 8'($urandom));
      end
    end
    if (finish) begin
      put_byte(8'd0);
      put_byte(ESC_EOB);
      repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
    end
  endtask

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      out_ready = 1'b1;
      repeat (steady ? 100 : $urandom_range(1, 12)) @(negedge clk);
      begin
        int stall;
        stall = pick_gap();
        if (stall > 0) begin
          out_ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
    end
  end

  initial begin
    logic [12:0] phase_heights [8];
    int phase_end;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    action = ACT_BYTE;
    palette_index = '0;
    palette_color = '0;
    stream_byte = '0;
    words_sent = 0;
    heights_used = 0;
    steady = 1'b0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed: ignored byte, palette extremes, unknown word, clipping, escapes
    put_byte(8'hFF);
    put_palette(8'd0, 24'hFFFFFF);
    put_palette(8'd255, 24'h000000);
    put_palette(8'd7, 24'hF80408);
    send_word(ACT_UNUSED, 8'hFF, 24'hFFFFFF, 8'hFF);
    put_begin();
    put_byte(8'd255);
    put_byte(8'd0);
    put_byte(8'd255);
    put_byte(8'd255);
    put_byte(8'd1);
    put_byte(8'd7);
    put_byte(8'd0);
    put_byte(ESC_EOL);
    put_byte(8'd0);
    put_byte(ESC_DELTA);
    put_byte(8'd255);
    put_byte(8'd1);
    put_byte(8'd0);
    put_byte(8'd3);
    put_byte(8'd255);
    put_byte(8'd0);
    put_byte(8'd7);
    put_byte(8'd0);
    put_byte(8'd0);
    put_byte(ESC_EOB);
    put_byte(8'd5);

    phase_heights = '{13'd320, 13'd1, 13'd0, 13'd8191, 13'd4096, 13'd321,
                      13'($urandom_range(2, 640)), 13'd320};
    phase_end = words_sent;
    foreach (phase_heights[p]) begin
      set_height(phase_heights[p]);
      phase_end += RANDOM_WORDS / 8;
      while (words_sent < phase_end) begin
        make_image($urandom_range(4, 20), (phase_heights[p] > 13'd400) ? 15 : 0,
                   $urandom_range(0, 3) != 0);
        // in the first height, hold off until the decoder has emptied after each image
        if (p == 0) wait_drained();
      end
    end

    steady = 1'b0;
    wait_drained();
    repeat (8) @(negedge clk);
    $display("Sent %0d input words over %0d image heights (0, 1, 4096, 8191 among them);",
             words_sent, heights_used);
    $display("checked %0d span words, %0d of them end-of-bitmap markers.",
             spans_checked, images_closed);
    if (mismatches == 0 && pending_spans == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
